// ----- src/rle_pkg.sv -----
// ----------------------------------------------------------------------------
// rle_pkg
// Shared types and codes of the raft leader election engine.
// ----------------------------------------------------------------------------
package rle_pkg;

   typedef enum logic [2:0] {
      REQ_START     = 3'd0,
      REQ_TICK      = 3'd1,
      REQ_VOTE_REQ  = 3'd2,
      REQ_VOTE_REPLY = 3'd3,
      REQ_HEARTBEAT = 3'd4,
      REQ_LOG_TAIL  = 3'd5
   } req_type_type;

   typedef enum logic [1:0] {
      ACT_NONE      = 2'd0,
      ACT_ELECTION  = 2'd1,
      ACT_HEARTBEAT = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ROLE_FOLLOWER  = 2'd0,
      ROLE_CANDIDATE = 2'd1,
      ROLE_LEADER    = 2'd2
   } role_type;

   typedef enum logic [2:0] {
      CSR_OWN_ID      = 3'd0,
      CSR_CLUSTER     = 3'd1,
      CSR_MIN_TIMEOUT = 3'd2,
      CSR_MAX_TIMEOUT = 3'd3,
      CSR_HB_PERIOD   = 3'd4
   } csr_index_type;

   localparam logic [3:0]  OWN_ID_RESET      = 4'd1;
   localparam logic [3:0]  CLUSTER_RESET     = 4'd3;
   localparam logic [15:0] MIN_TIMEOUT_RESET = 16'd150;
   localparam logic [15:0] MAX_TIMEOUT_RESET = 16'd300;
   localparam logic [15:0] HB_PERIOD_RESET   = 16'd50;

   localparam logic [3:0]  NO_NODE = 4'd0;

endpackage

// ----- src/raft_leader_election.sv -----
// ----------------------------------------------------------------------------
// raft election engine
// Raft election engine for one node: role, term, votes, deadlines, log tail.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on the req_ channel (valid/stall) and each event gives one
//   result on the rsp_ channel (valid/stall). An event is taken when
//   req_valid is high and req_stall is low; a result is taken when rsp_valid
//   is high and rsp_stall is low.
//   The event is captured in an input register, and one pass of logic then
//   updates the node state and loads the result register. Throughput is one
//   event per cycle while the receiver does not stall, limited by the
//   single state update per cycle.
//   While the receiver stalls, the result register holds its item and one
//   more event can still be captured; after that req_stall rises.
//   Reset clears the pipeline, loads the default configuration and puts the
//   node in follower role at term zero with no vote, no leader and an empty
//   vote bitmap; req_stall is high and csr_ready low while reset is high.
//   The csr_ channel is ready whenever reset is low and should be written
//   only while no event is in flight.
// ----------------------------------------------------------------------------
module raft_leader_election #(
   parameter int MAX_NODES = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [63:0] req_now_ms,
   input  logic [63:0] req_peer_term,
   input  logic [3:0]  req_peer_id,
   input  logic [63:0] req_log_index,
   input  logic [63:0] req_log_term,
   input  logic        req_granted_in,
   input  logic [15:0] req_random_offset,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_tick_action,
   output logic [63:0] rsp_reply_term,
   output logic        rsp_reply_ok,
   output logic        rsp_won_leadership,
   output logic [1:0]  rsp_role,
   output logic [63:0] rsp_term_now,
   output logic [3:0]  rsp_leader_now,
   output logic [3:0]  rsp_voted_now,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int CntW = $clog2(MAX_NODES + 1);
   localparam int CmpW = (CntW > 3) ? CntW : 3;

   // configuration
   logic [3:0]  own_id_ff;
   logic [3:0]  cluster_ff;
   logic [15:0] min_to_ff;
   logic [15:0] max_to_ff;
   logic [15:0] hb_period_ff;

   // input stage
   logic                  in_valid_ff;
   rle_pkg::req_type_type type_ff;
   logic [63:0]           now_ff;
   logic [63:0]           pterm_ff;
   logic [3:0]            pid_ff;
   logic [63:0]           lidx_ff;
   logic [63:0]           lterm_ff;
   logic                  granted_ff;
   logic [15:0]           offset_ff;

   // node state
   rle_pkg::role_type     role_ff, role_in;
   logic [63:0]           term_ff, term_in;
   logic [3:0]            vote_ff, vote_in;
   logic [3:0]            leader_ff, leader_in;
   logic [MAX_NODES-1:0]  bitmap_ff, bitmap_in;
   logic [CntW-1:0]       count_ff, count_in;
   logic [63:0]           deadline_ff, deadline_in;
   logic [63:0]           last_hb_ff, last_hb_in;
   logic [63:0]           tail_idx_ff, tail_idx_in;
   logic [63:0]           tail_term_ff, tail_term_in;

   // result register
   logic                  out_valid_ff;
   rle_pkg::action_type   action_ff, action_in;
   logic [63:0]           rterm_ff, rterm_in;
   logic                  ok_ff, ok_in;
   logic                  won_ff, won_in;

   logic                  advance;
   logic                  accept;

   logic [16:0]           to_sum;
   logic [15:0]           to_clamped;
   logic [63:0]           new_deadline;
   logic                  hb_due;
   logic                  fresh;
   logic [MAX_NODES-1:0]  own_hit;
   logic [MAX_NODES-1:0]  pid_hit;
   logic                  pid_new;
   logic [CntW-1:0]       self_count;
   logic [CntW-1:0]       reply_count;
   logic                  self_major;
   logic                  reply_major;
   logic [3:0]            vote_eff;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = reset || (in_valid_ff && !advance);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = !reset;

   always_comb begin
      for (int i = 0; i < MAX_NODES; i++) begin
         own_hit[i] = (int'(own_id_ff) == i);
         pid_hit[i] = (int'(pid_ff) == i);
      end
   end

   assign to_sum       = {1'b0, min_to_ff} + {1'b0, offset_ff};
   assign to_clamped   = (to_sum > {1'b0, max_to_ff}) ? max_to_ff : to_sum[15:0];
   assign new_deadline = now_ff + {48'd0, to_clamped};
   assign hb_due       = now_ff >= (last_hb_ff + {48'd0, hb_period_ff});
   assign fresh        = (lterm_ff != tail_term_ff) ? (lterm_ff > tail_term_ff)
                                                    : (lidx_ff >= tail_idx_ff);
   assign pid_new      = |(pid_hit & ~bitmap_ff);
   assign self_count   = CntW'(|own_hit);
   assign reply_count  = count_ff + CntW'(pid_new);
   assign self_major   = CmpW'(self_count) > CmpW'(cluster_ff[3:1]);
   assign reply_major  = CmpW'(reply_count) > CmpW'(cluster_ff[3:1]);
   assign vote_eff     = (pterm_ff > term_ff) ? rle_pkg::NO_NODE : vote_ff;

   always_comb begin
      role_in      = role_ff;
      term_in      = term_ff;
      vote_in      = vote_ff;
      leader_in    = leader_ff;
      bitmap_in    = bitmap_ff;
      count_in     = count_ff;
      deadline_in  = deadline_ff;
      last_hb_in   = last_hb_ff;
      tail_idx_in  = tail_idx_ff;
      tail_term_in = tail_term_ff;
      action_in    = rle_pkg::ACT_NONE;
      rterm_in     = '0;
      ok_in        = 1'b0;
      won_in       = 1'b0;
      case (type_ff)
         rle_pkg::REQ_START: begin
            role_in     = rle_pkg::ROLE_FOLLOWER;
            leader_in   = rle_pkg::NO_NODE;
            vote_in     = rle_pkg::NO_NODE;
            bitmap_in   = '0;
            count_in    = '0;
            deadline_in = new_deadline;
            last_hb_in  = now_ff;
         end
         rle_pkg::REQ_TICK: begin
            if (role_ff == rle_pkg::ROLE_LEADER) begin
               if (hb_due) begin
                  last_hb_in = now_ff;
                  action_in  = rle_pkg::ACT_HEARTBEAT;
               end
            end else if (now_ff >= deadline_ff) begin
               term_in     = term_ff + 64'd1;
               vote_in     = own_id_ff;
               deadline_in = new_deadline;
               if (self_major) begin
                  role_in    = rle_pkg::ROLE_LEADER;
                  leader_in  = own_id_ff;
                  last_hb_in = now_ff;
                  bitmap_in  = '0;
                  count_in   = '0;
                  action_in  = rle_pkg::ACT_HEARTBEAT;
               end else begin
                  role_in    = rle_pkg::ROLE_CANDIDATE;
                  leader_in  = rle_pkg::NO_NODE;
                  bitmap_in  = own_hit;
                  count_in   = self_count;
                  action_in  = rle_pkg::ACT_ELECTION;
               end
            end
         end
         rle_pkg::REQ_VOTE_REQ: begin
            rterm_in = term_ff;
            if (pterm_ff >= term_ff) begin
               rterm_in = pterm_ff;
               if (pterm_ff > term_ff) begin
                  term_in     = pterm_ff;
                  vote_in     = rle_pkg::NO_NODE;
                  role_in     = rle_pkg::ROLE_FOLLOWER;
                  leader_in   = rle_pkg::NO_NODE;
                  bitmap_in   = '0;
                  count_in    = '0;
                  deadline_in = new_deadline;
               end
               if (pid_ff != rle_pkg::NO_NODE && fresh &&
                   (vote_eff == rle_pkg::NO_NODE || vote_eff == pid_ff)) begin
                  vote_in     = pid_ff;
                  leader_in   = rle_pkg::NO_NODE;
                  deadline_in = new_deadline;
                  ok_in       = 1'b1;
               end
            end
         end
         rle_pkg::REQ_VOTE_REPLY: begin
            if (pterm_ff > term_ff) begin
               term_in     = pterm_ff;
               vote_in     = rle_pkg::NO_NODE;
               role_in     = rle_pkg::ROLE_FOLLOWER;
               leader_in   = rle_pkg::NO_NODE;
               bitmap_in   = '0;
               count_in    = '0;
               deadline_in = new_deadline;
            end else if (role_ff == rle_pkg::ROLE_CANDIDATE && pterm_ff == term_ff &&
                         granted_ff) begin
               if (reply_major) begin
                  role_in    = rle_pkg::ROLE_LEADER;
                  leader_in  = own_id_ff;
                  last_hb_in = now_ff;
                  bitmap_in  = '0;
                  count_in   = '0;
                  won_in     = 1'b1;
               end else begin
                  bitmap_in  = bitmap_ff | pid_hit;
                  count_in   = reply_count;
               end
            end
         end
         rle_pkg::REQ_HEARTBEAT: begin
            rterm_in = term_ff;
            if (pterm_ff >= term_ff) begin
               if (pterm_ff > term_ff) begin
                  term_in = pterm_ff;
                  vote_in = rle_pkg::NO_NODE;
               end
               role_in     = rle_pkg::ROLE_FOLLOWER;
               leader_in   = pid_ff;
               bitmap_in   = '0;
               count_in    = '0;
               deadline_in = new_deadline;
               rterm_in    = pterm_ff;
               ok_in       = 1'b1;
            end
         end
         rle_pkg::REQ_LOG_TAIL: begin
            tail_idx_in  = lidx_ff;
            tail_term_in = lterm_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff    <= rle_pkg::OWN_ID_RESET;
         cluster_ff   <= rle_pkg::CLUSTER_RESET;
         min_to_ff    <= rle_pkg::MIN_TIMEOUT_RESET;
         max_to_ff    <= rle_pkg::MAX_TIMEOUT_RESET;
         hb_period_ff <= rle_pkg::HB_PERIOD_RESET;
      end else if (csr_valid && csr_ready) begin
         case (rle_pkg::csr_index_type'(csr_index))
            rle_pkg::CSR_OWN_ID:      own_id_ff    <= csr_data[3:0];
            rle_pkg::CSR_CLUSTER:     cluster_ff   <= csr_data[3:0];
            rle_pkg::CSR_MIN_TIMEOUT: min_to_ff    <= csr_data;
            rle_pkg::CSR_MAX_TIMEOUT: max_to_ff    <= csr_data;
            rle_pkg::CSR_HB_PERIOD:   hb_period_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff    <= rle_pkg::req_type_type'(req_type);
         now_ff     <= req_now_ms;
         pterm_ff   <= req_peer_term;
         pid_ff     <= req_peer_id;
         lidx_ff    <= req_log_index;
         lterm_ff   <= req_log_term;
         granted_ff <= req_granted_in;
         offset_ff  <= req_random_offset;
      end
      if (advance && in_valid_ff) begin
         action_ff <= action_in;
         rterm_ff  <= rterm_in;
         ok_ff     <= ok_in;
         won_ff    <= won_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         role_ff      <= rle_pkg::ROLE_FOLLOWER;
         term_ff      <= '0;
         vote_ff      <= rle_pkg::NO_NODE;
         leader_ff    <= rle_pkg::NO_NODE;
         bitmap_ff    <= '0;
         count_ff     <= '0;
         deadline_ff  <= '0;
         last_hb_ff   <= '0;
         tail_idx_ff  <= '0;
         tail_term_ff <= '0;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance && in_valid_ff) begin
            role_ff      <= role_in;
            term_ff      <= term_in;
            vote_ff      <= vote_in;
            leader_ff    <= leader_in;
            bitmap_ff    <= bitmap_in;
            count_ff     <= count_in;
            deadline_ff  <= deadline_in;
            last_hb_ff   <= last_hb_in;
            tail_idx_ff  <= tail_idx_in;
            tail_term_ff <= tail_term_in;
         end
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_tick_action    = action_ff;
   assign rsp_reply_term     = rterm_ff;
   assign rsp_reply_ok       = ok_ff;
   assign rsp_won_leadership = won_ff;
   assign rsp_role           = role_ff;
   assign rsp_term_now       = term_ff;
   assign rsp_leader_now     = leader_ff;
   assign rsp_voted_now      = vote_ff;

endmodule

// ----- src/rle_checker.sv -----
// ----------------------------------------------------------------------------
// rle_checker
// Port-level checks of the raft leader election engine, bound to the top.
// ----------------------------------------------------------------------------
module rle_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_tick_action,
   input logic [63:0] rsp_reply_term,
   input logic        rsp_reply_ok,
   input logic        rsp_won_leadership,
   input logic [1:0]  rsp_role,
   input logic [63:0] rsp_term_now
);

   // stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_term_now) && $stable(rsp_role))
      else $error("result item changed while stalled");

   a_won_leader: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_won_leadership |->
         rsp_role == rle_pkg::ROLE_LEADER && rsp_tick_action == rle_pkg::ACT_NONE &&
         !rsp_reply_ok)
      else $error("won leadership without leader role");

   a_hb_leader: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tick_action == rle_pkg::ACT_HEARTBEAT |->
         rsp_role == rle_pkg::ROLE_LEADER)
      else $error("heartbeat action from a non-leader");

   a_ok_term: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reply_ok |-> rsp_reply_term == rsp_term_now)
      else $error("accepted reply with stale term");

endmodule

bind raft_leader_election rle_checker u_rle_checker (.*);
